### src/e2c_pkg.sv
// Package for the epoch seconds to calendar converter.
// Holds field widths, reciprocal constants, the month table and shared types; no dependencies.
package e2c_pkg;

   localparam int EpochWidth  = 32;
   localparam int YearWidth   = 12;
   localparam int MonthWidth  = 4;
   localparam int DayWidth    = 5;
   localparam int HourWidth   = 5;
   localparam int MinuteWidth = 6;
   localparam int SecWidth    = 6;
   localparam int DoyWidth    = 9;
   localparam int NumStages   = 7;

   // Whole days: (t >> 7) * DayRecip >> 35 equals t / 86400 for every 32-bit t.
   localparam logic [25:0] DayRecip     = 26'd50903317;
   localparam logic [31:0] SecsPerDay   = 32'd86400;
   // Four-year cycles from 1969: d * CycleRecip >> 27 equals d / 1461 for d below 2^16.
   localparam logic [16:0] CycleRecip   = 17'd91868;
   localparam logic [15:0] DaysPerCycle = 16'd1461;
   localparam logic [15:0] DaysToEpoch  = 16'd365;
   localparam logic [10:0] DaysPerYear  = 11'd365;
   localparam logic [11:0] YearBase     = 12'd1969;
   // Hours: (rest >> 4) * HourRecip >> 20 equals rest / 3600 below 86400.
   localparam logic [12:0] HourRecip    = 13'd4661;
   localparam logic [16:0] SecsPerHour  = 17'd3600;
   // Minutes: (rest >> 2) * MinRecip >> 16 equals rest / 60 below 3600.
   localparam logic [12:0] MinRecip     = 13'd4370;
   localparam logic [11:0] SecsPerMin   = 12'd60;

   localparam logic [MonthWidth-1:0] MonthJan = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;

   typedef struct packed {
      logic [MonthWidth-1:0] month;
      logic [DoyWidth-1:0]   first_doy;
   } e2c_month_type;

   typedef struct packed {
      logic [YearWidth-1:0]   year;
      logic [MonthWidth-1:0]  month;
      logic [DayWidth-1:0]    day;
      logic [HourWidth-1:0]   hour;
      logic [MinuteWidth-1:0] minute;
      logic [SecWidth-1:0]    sec;
   } e2c_result_type;

   // Zero-based day of the year on which a month starts.
   function automatic logic [DoyWidth-1:0] month_first_doy(input logic [MonthWidth-1:0] month,
                                                           input logic leap);
      logic [DoyWidth-1:0] base;
      case (month)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && month > MonthFeb) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

### src/e2c_if.sv
// Valid/ready channel interfaces for the epoch seconds to calendar converter.
// Depends on e2c_pkg for the field widths.
interface e2c_req_if import e2c_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [EpochWidth-1:0] epoch_seconds;

   modport source(output valid, output epoch_seconds, input ready);
   modport sink(input valid, input epoch_seconds, output ready);
endinterface

interface e2c_rsp_if import e2c_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [YearWidth-1:0]   year;
   logic [MonthWidth-1:0]  month;
   logic [DayWidth-1:0]    day;
   logic [HourWidth-1:0]   hour;
   logic [MinuteWidth-1:0] minute;
   logic [SecWidth-1:0]    sec;

   modport source(output valid, output year, output month, output day, output hour,
                  output minute, output sec, input ready);
   modport sink(input valid, input year, input month, input day, input hour,
                input minute, input sec, output ready);
endinterface

### src/e2c_month.sv
// Month lookup: finds the month and its first day from a zero-based day of the year.
// Depends on e2c_pkg for the month table and e2c_month_type.
module e2c_month import e2c_pkg::*; (
   input  logic [DoyWidth-1:0] doy,
   input  logic                leap,
   output e2c_month_type       info
);

   logic [MonthWidth-1:0] count;

   always_comb begin
      count = MonthJan;
      for (int m = 2; m <= 12; m++) begin
         if (doy >= month_first_doy(MonthWidth'(m), leap)) begin
            count = count + 4'd1;
         end
      end
      info.month     = count;
      info.first_doy = month_first_doy(count, leap);
   end

endmodule

### src/epoch_seconds_to_calendar.sv
// Top level of the epoch seconds to calendar converter: a seven-stage pipeline.
// Depends on e2c_pkg, e2c_if (e2c_req_if, e2c_rsp_if) and e2c_month.
//
//   Channel  Direction  Handshake    Payload
//   req      in         valid/ready  epoch_seconds[31:0]
//   rsp      out        valid/ready  year, month, day, hour, minute, sec
//
// A beat enters every cycle unless the full pipeline is stalled by rsp.ready.
// The depth is set by the chain of constant-reciprocal multiplies and their remainders.
// Each stage holds while the stage after it is full and stalled, so bubbles close up.
// Synchronous reset clears only the stage valid bits.
module epoch_seconds_to_calendar import e2c_pkg::*; (
   input logic       clock,
   input logic       reset,
   e2c_req_if.sink   req,
   e2c_rsp_if.source rsp
);

   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] adv;

   logic [31:0] s1_t_ff;
   logic [15:0] s1_qday_ff;
   logic [16:0] s2_rest_ff;
   logic [15:0] s2_dshift_ff;
   logic [16:0] s3_rest_ff;
   logic [15:0] s3_dshift_ff;
   logic [HourWidth-1:0] s3_hour_ff;
   logic [5:0]  s3_cyc_ff;
   logic [11:0] s4_rest2_ff;
   logic [10:0] s4_r4_ff;
   logic [HourWidth-1:0] s4_hour_ff;
   logic [5:0]  s4_cyc_ff;
   logic [11:0] s5_rest2_ff;
   logic [MinuteWidth-1:0] s5_minute_ff;
   logic [HourWidth-1:0] s5_hour_ff;
   logic [YearWidth-1:0] s5_year_ff;
   logic [DoyWidth-1:0] s5_doy_ff;
   logic        s5_leap_ff;
   logic [SecWidth-1:0] s6_sec_ff;
   logic [MinuteWidth-1:0] s6_minute_ff;
   logic [HourWidth-1:0] s6_hour_ff;
   logic [YearWidth-1:0] s6_year_ff;
   logic [DoyWidth-1:0] s6_doy_ff;
   e2c_month_type s6_month_ff;
   e2c_result_type out_ff;

   logic [50:0] qday_prod;
   logic [15:0] qday_in;
   logic [31:0] day_base;
   logic [16:0] rest_in;
   logic [15:0] dshift_in;
   logic [25:0] hour_prod;
   logic [HourWidth-1:0] hour_in;
   logic [32:0] cyc_prod;
   logic [5:0]  cyc_in;
   logic [16:0] hour_base;
   logic [11:0] rest2_in;
   logic [15:0] cyc_base;
   logic [10:0] r4_in;
   logic [1:0]  yic;
   logic [10:0] yic_base;
   logic [DoyWidth-1:0] doy_in;
   logic        leap_in;
   logic [YearWidth-1:0] year_in;
   logic [22:0] minute_prod;
   logic [MinuteWidth-1:0] minute_in;
   logic [11:0] minute_base;
   logic [SecWidth-1:0] sec_in;
   e2c_month_type month_in;
   logic [DayWidth-1:0] day_in;

   e2c_month u_month (
      .doy  (s5_doy_ff),
      .leap (s5_leap_ff),
      .info (month_in)
   );

   always_comb begin
      adv[NumStages-1] = !vld_ff[NumStages-1] || rsp.ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      qday_prod = 51'(req.epoch_seconds[31:7]) * 51'(DayRecip);
      qday_in   = qday_prod[50:35];

      day_base  = 32'(s1_qday_ff) * SecsPerDay;
      rest_in   = 17'(s1_t_ff - day_base);
      dshift_in = s1_qday_ff + DaysToEpoch;

      hour_prod = 26'(s2_rest_ff[16:4]) * 26'(HourRecip);
      hour_in   = hour_prod[24:20];
      cyc_prod  = 33'(s2_dshift_ff) * 33'(CycleRecip);
      cyc_in    = cyc_prod[32:27];

      hour_base = 17'(s3_hour_ff) * SecsPerHour;
      rest2_in  = 12'(s3_rest_ff - hour_base);
      cyc_base  = 16'(s3_cyc_ff) * DaysPerCycle;
      r4_in     = 11'(s3_dshift_ff - cyc_base);

      if (s4_r4_ff >= 11'(3 * 365)) begin
         yic = 2'd3;
      end else if (s4_r4_ff >= 11'(2 * 365)) begin
         yic = 2'd2;
      end else if (s4_r4_ff >= DaysPerYear) begin
         yic = 2'd1;
      end else begin
         yic = 2'd0;
      end
      yic_base    = 11'(yic) * DaysPerYear;
      doy_in      = DoyWidth'(s4_r4_ff - yic_base);
      leap_in     = (yic == 2'd3);
      year_in     = YearBase + {4'd0, s4_cyc_ff, 2'b00} + 12'(yic);
      minute_prod = 23'(s4_rest2_ff[11:2]) * 23'(MinRecip);
      minute_in   = minute_prod[21:16];

      minute_base = 12'(s5_minute_ff) * SecsPerMin;
      sec_in      = SecWidth'(s5_rest2_ff - minute_base);

      day_in = DayWidth'(s6_doy_ff - s6_month_ff.first_doy + 9'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req.valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_t_ff    <= req.epoch_seconds;
         s1_qday_ff <= qday_in;
      end
      if (adv[1]) begin
         s2_rest_ff   <= rest_in;
         s2_dshift_ff <= dshift_in;
      end
      if (adv[2]) begin
         s3_rest_ff   <= s2_rest_ff;
         s3_dshift_ff <= s2_dshift_ff;
         s3_hour_ff   <= hour_in;
         s3_cyc_ff    <= cyc_in;
      end
      if (adv[3]) begin
         s4_rest2_ff <= rest2_in;
         s4_r4_ff    <= r4_in;
         s4_hour_ff  <= s3_hour_ff;
         s4_cyc_ff   <= s3_cyc_ff;
      end
      if (adv[4]) begin
         s5_rest2_ff  <= s4_rest2_ff;
         s5_minute_ff <= minute_in;
         s5_hour_ff   <= s4_hour_ff;
         s5_year_ff   <= year_in;
         s5_doy_ff    <= doy_in;
         s5_leap_ff   <= leap_in;
      end
      if (adv[5]) begin
         s6_sec_ff    <= sec_in;
         s6_minute_ff <= s5_minute_ff;
         s6_hour_ff   <= s5_hour_ff;
         s6_year_ff   <= s5_year_ff;
         s6_doy_ff    <= s5_doy_ff;
         s6_month_ff  <= month_in;
      end
      if (adv[6]) begin
         out_ff.year   <= s6_year_ff;
         out_ff.month  <= s6_month_ff.month;
         out_ff.day    <= day_in;
         out_ff.hour   <= s6_hour_ff;
         out_ff.minute <= s6_minute_ff;
         out_ff.sec    <= s6_sec_ff;
      end
   end

   assign req.ready  = adv[0];
   assign rsp.valid  = vld_ff[NumStages-1];
   assign rsp.year   = out_ff.year;
   assign rsp.month  = out_ff.month;
   assign rsp.day    = out_ff.day;
   assign rsp.hour   = out_ff.hour;
   assign rsp.minute = out_ff.minute;
   assign rsp.sec    = out_ff.sec;

endmodule
